// ===== design/pvsa_pkg.sv =====
// Shared types and constants of the packet validate, store and aggregate unit.
package pvsa_pkg;

	typedef enum logic [2:0] {
		OC_ACCEPT    = 3'd0,
		OC_BAD_MAGIC = 3'd1,
		OC_BAD_LEN   = 3'd2,
		OC_BAD_CHAN  = 3'd3,
		OC_BAD_CHECK = 3'd4,
		OC_NO_SPACE  = 3'd5
	} outcome_t;

	localparam int NUM_OUTCOMES = 6;

	localparam logic [0:0] REQ_SUBMIT = 1'b0;
	localparam logic [0:0] REQ_READ   = 1'b1;

	localparam logic [7:0] CFG_MAGIC       = 8'd0;
	localparam logic [7:0] CFG_MIN_LEN     = 8'd1;
	localparam logic [7:0] CFG_MAX_LEN     = 8'd2;
	localparam logic [7:0] CFG_STORE_LIMIT = 8'd3;

	localparam logic [7:0] MAGIC_RST       = 8'h4D;
	localparam logic [7:0] MIN_LEN_RST     = 8'd4;
	localparam logic [7:0] MAX_LEN_RST     = 8'd64;
	localparam logic [5:0] STORE_LIMIT_RST = 6'd24;

	localparam logic [20:0] SUM_MAX   = 21'h1FFFFF;
	localparam logic [5:0]  CNT_MAX   = 6'h3F;
	localparam logic [15:0] TALLY_MAX = 16'hFFFF;

	typedef struct packed {
		logic [0:0]  req_type;
		logic [7:0]  magic;
		logic [7:0]  chan;
		logic [7:0]  len;
		logic [7:0]  crc;
		logic [15:0] value;
		logic [4:0]  read_index;
	} req_t;

	typedef struct packed {
		outcome_t    outcome;
		logic [4:0]  slot;
		logic [5:0]  fill_level;
		logic [20:0] channel_total;
		logic [5:0]  channel_count;
		logic [15:0] outcome_total;
		logic [1:0]  entry_chan;
		logic [15:0] entry_value;
	} rsp_t;

endpackage

// ===== design/packet_validate_store_aggregate_unit.sv =====
// Top level of the packet validate, store and aggregate unit.
//
// Request channel: a word on req is taken at a rising edge with start high and busy
// low. A submit word is checked (signature, length window, channel, check byte,
// store space) and, if good, appended to the store and added to its channel totals.
// A read word returns the stored entry at read_index, or zeros past the fill level.
// Every word gives one result word on result, marked by done for one cycle, via the
// input and result registers. The receiver cannot stall; results are never held.
// A word can be taken on every cycle in which busy is low: one word per cycle, set
// by the single pass from the input register through the check logic into the
// result register, with the store and channel totals updated in that same pass.
// Busy is high only in a cycle where a register write is taken.
// Register channel: cfg_index and cfg_data, written when cfg_valid and cfg_ready
// are high; cfg_ready is low while a word is in the input register. Writes to
// indexes beyond the register list are taken and ignored.
// Reset clears the registers to their defaults, empties the store, zeroes the
// channel totals and the outcome tallies, and drops any word in flight.
module packet_validate_store_aggregate_unit #(
	parameter int STORE_DEPTH  = 32,
	parameter int NUM_CHANNELS = 4,
	parameter int VALUE_BITS   = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  pvsa_pkg::req_t req,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [7:0]    cfg_index,
	input  logic [7:0]    cfg_data,
	output logic          done,
	output pvsa_pkg::rsp_t result
);

	localparam int AW  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int CW  = $clog2(STORE_DEPTH + 1);
	localparam int MW  = (CW > 6) ? CW : 6;
	localparam int CHW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int VW  = (VALUE_BITS < 16) ? VALUE_BITS : 16;
	localparam int EW  = 2 + VW;

	logic [7:0] magic_value_q;
	logic [7:0] min_len_q;
	logic [7:0] max_len_q;
	logic [5:0] store_limit_q;

	logic           valid_s1;
	pvsa_pkg::req_t req_s1;

	logic [CW-1:0] count_q;
	logic [20:0]   sum_q   [NUM_CHANNELS];
	logic [5:0]    cnt_q   [NUM_CHANNELS];
	logic [15:0]   tally_q [pvsa_pkg::NUM_OUTCOMES];

	logic [EW-1:0] store_mem [STORE_DEPTH];
	logic [EW-1:0] rd_q;
	logic          rd_ok_q;

	logic           done_q;
	pvsa_pkg::rsp_t rsp_q;

	logic              take_item;
	logic              take_cfg;
	logic              ch_ok;
	logic              len_ok;
	logic [CHW-1:0]    ch_idx;
	logic [VW-1:0]     val;
	logic [7:0]        check;
	logic [MW-1:0]     count_ext;
	logic [MW-1:0]     count_inc;
	logic [MW-1:0]     limit_ext;
	logic [MW+4:0]     ridx_ext;
	logic [AW-1:0]     rd_addr;
	logic              rd_ok;
	pvsa_pkg::outcome_t oc;
	logic              take;
	logic              tally_upd;
	logic [20:0]       sum_sel;
	logic [21:0]       sum_add;
	logic [20:0]       sum_new;
	logic [5:0]        cnt_sel;
	logic [5:0]        cnt_new;
	logic [15:0]       tally_sel;
	logic [15:0]       tally_new;
	pvsa_pkg::rsp_t    rsp_d;

	assign cfg_ready = ~valid_s1;
	assign take_cfg  = cfg_valid & cfg_ready;
	assign busy      = take_cfg;
	assign take_item = start & ~busy;

	always_comb begin
		ch_ok     = {1'b0, req_s1.chan} < 9'(NUM_CHANNELS);
		len_ok    = (req_s1.len >= min_len_q) && (req_s1.len <= max_len_q);
		ch_idx    = req_s1.chan[CHW-1:0];
		val       = req_s1.value[VW-1:0];
		check     = req_s1.magic ^ req_s1.chan ^ req_s1.len;
		count_ext = MW'(count_q);
		count_inc = count_ext + MW'(1);
		limit_ext = (MW'(store_limit_q) > MW'(STORE_DEPTH)) ? MW'(STORE_DEPTH)
			: MW'(store_limit_q);
		ridx_ext  = (MW + 5)'(req_s1.read_index);
		rd_addr   = ridx_ext[AW-1:0];
		rd_ok     = (req_s1.req_type == pvsa_pkg::REQ_READ) &&
			(ridx_ext[MW-1:0] < count_ext);

		priority if (req_s1.magic != magic_value_q) begin
			oc = pvsa_pkg::OC_BAD_MAGIC;
		end else if (!len_ok) begin
			oc = pvsa_pkg::OC_BAD_LEN;
		end else if (!ch_ok) begin
			oc = pvsa_pkg::OC_BAD_CHAN;
		end else if (req_s1.crc != check) begin
			oc = pvsa_pkg::OC_BAD_CHECK;
		end else if (count_ext >= limit_ext) begin
			oc = pvsa_pkg::OC_NO_SPACE;
		end else begin
			oc = pvsa_pkg::OC_ACCEPT;
		end

		tally_upd = valid_s1 && (req_s1.req_type == pvsa_pkg::REQ_SUBMIT);
		take      = tally_upd && (oc == pvsa_pkg::OC_ACCEPT);

		sum_sel = sum_q[ch_idx];
		sum_add = {1'b0, sum_sel} + 22'(val);
		sum_new = sum_add[21] ? pvsa_pkg::SUM_MAX : sum_add[20:0];
		cnt_sel = cnt_q[ch_idx];
		cnt_new = (cnt_sel == pvsa_pkg::CNT_MAX) ? cnt_sel : cnt_sel + 6'd1;
		tally_sel = tally_q[oc];
		tally_new = (tally_sel == pvsa_pkg::TALLY_MAX) ? tally_sel : tally_sel + 16'd1;

		rsp_d = '0;
		if (req_s1.req_type == pvsa_pkg::REQ_READ) begin
			rsp_d.outcome    = pvsa_pkg::OC_ACCEPT;
			rsp_d.fill_level = count_ext[5:0];
		end else begin
			rsp_d.outcome       = oc;
			rsp_d.outcome_total = tally_new;
			if (take) begin
				rsp_d.slot          = count_ext[4:0];
				rsp_d.fill_level    = count_inc[5:0];
				rsp_d.channel_total = sum_new;
				rsp_d.channel_count = cnt_new;
			end else begin
				rsp_d.fill_level = count_ext[5:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_value_q <= pvsa_pkg::MAGIC_RST;
			min_len_q     <= pvsa_pkg::MIN_LEN_RST;
			max_len_q     <= pvsa_pkg::MAX_LEN_RST;
			store_limit_q <= pvsa_pkg::STORE_LIMIT_RST;
		end else if (take_cfg) begin
			unique case (cfg_index)
				pvsa_pkg::CFG_MAGIC:       magic_value_q <= cfg_data;
				pvsa_pkg::CFG_MIN_LEN:     min_len_q     <= cfg_data;
				pvsa_pkg::CFG_MAX_LEN:     max_len_q     <= cfg_data;
				pvsa_pkg::CFG_STORE_LIMIT: store_limit_q <= cfg_data[5:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			done_q   <= 1'b0;
			count_q  <= '0;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				sum_q[i] <= '0;
				cnt_q[i] <= '0;
			end
			for (int i = 0; i < pvsa_pkg::NUM_OUTCOMES; i++) begin
				tally_q[i] <= '0;
			end
		end else begin
			valid_s1 <= take_item;
			done_q   <= valid_s1;
			if (tally_upd) begin
				tally_q[oc] <= tally_new;
			end
			if (take) begin
				count_q         <= count_inc[CW-1:0];
				sum_q[ch_idx]   <= sum_new;
				cnt_q[ch_idx]   <= cnt_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_item) begin
			req_s1 <= req;
		end
		rsp_q   <= rsp_d;
		rd_ok_q <= rd_ok;
		rd_q    <= store_mem[rd_addr];
		if (take) begin
			store_mem[count_q[AW-1:0]] <= {req_s1.chan[1:0], val};
		end
	end

	always_comb begin
		result = rsp_q;
		if (rd_ok_q) begin
			result.entry_chan  = rd_q[EW-1:EW-2];
			result.entry_value = 16'(rd_q[VW-1:0]);
		end
	end

	assign done = done_q;

endmodule

// ===== design/pvsa_checker.sv =====
// Port checker of the packet validate, store and aggregate unit, with its bind.
module pvsa_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input logic           cfg_valid,
	input logic           cfg_ready,
	input logic           done,
	input pvsa_pkg::rsp_t result
);

	a_done_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> ##1 done)
		else $error("result word missing two edges after a taken request");

	a_no_spurious_done: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |=> ##1 !done)
		else $error("result word without a taken request");

	a_cfg_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cfg_valid && cfg_ready && start && !busy))
		else $error("register write and request taken on the same edge");

	a_reject_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.outcome != pvsa_pkg::OC_ACCEPT) |->
		(result.slot == 5'd0 && result.channel_total == 21'd0 &&
		 result.channel_count == 6'd0 && result.entry_chan == 2'd0 &&
		 result.entry_value == 16'd0 && result.outcome_total != 16'd0))
		else $error("refused packet shows store or channel data");

endmodule

bind packet_validate_store_aggregate_unit pvsa_checker u_pvsa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready),
	.done      (done),
	.result    (result)
);

// ===== verif/tb_packet_validate_store_aggregate_unit.sv =====
`timescale 1ns / 100ps
// Testbench of the packet validate, store and aggregate unit: directed table, then random words.
module tb_packet_validate_store_aggregate_unit;

	localparam int STORE_SLOTS = 32;
	localparam int CHANNELS = 4;
	localparam int unsigned CYCLE_LIMIT = 40000;
	localparam logic [7:0] CFG_UNUSED_LO = 8'd4;
	localparam logic [7:0] CFG_UNUSED_HI = 8'hFF;

	typedef struct {
		pvsa_pkg::req_t word;
		bit             typed;
		pvsa_pkg::rsp_t want;
	} stim_row_t;

	logic           clk;
	logic           arst_n;
	logic           start;
	logic           busy;
	pvsa_pkg::req_t req;
	logic           cfg_valid;
	logic           cfg_ready;
	logic [7:0]     cfg_index;
	logic [7:0]     cfg_data;
	logic           done;
	pvsa_pkg::rsp_t result;

	logic [7:0]  reg_magic;
	logic [7:0]  reg_min_len;
	logic [7:0]  reg_max_len;
	logic [5:0]  reg_store_limit;
	logic [17:0] entry_mem [STORE_SLOTS];
	logic [5:0]  fill_count;
	logic [20:0] lane_sum [CHANNELS];
	logic [5:0]  lane_count [CHANNELS];
	logic [15:0] tally_by_outcome [pvsa_pkg::NUM_OUTCOMES];

	pvsa_pkg::rsp_t pending_results[$];
	stim_row_t      directed_rows[$];
	int unsigned    mismatch_count = 0;
	int unsigned    cycle_count = 0;

	packet_validate_store_aggregate_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.done(done),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("packet_validate_store_aggregate_unit test failed");
			$finish;
		end
	end

	function automatic pvsa_pkg::req_t sub(input logic [7:0] magic, chan, len, crc,
			input logic [15:0] value);
		pvsa_pkg::req_t w;
		w = '0;
		w.req_type = pvsa_pkg::REQ_SUBMIT;
		w.magic = magic;
		w.chan = chan;
		w.len = len;
		w.crc = crc;
		w.value = value;
		return w;
	endfunction

	function automatic pvsa_pkg::req_t rd(input logic [4:0] idx);
		pvsa_pkg::req_t w;
		w = '0;
		w.req_type = pvsa_pkg::REQ_READ;
		w.read_index = idx;
		return w;
	endfunction

	function automatic pvsa_pkg::rsp_t result_word(input pvsa_pkg::outcome_t oc,
			input logic [4:0] slot, input logic [5:0] fill, input logic [20:0] tot,
			input logic [5:0] cnt, input logic [15:0] otot, input logic [1:0] ech,
			input logic [15:0] eval);
		pvsa_pkg::rsp_t r;
		r.outcome = oc;
		r.slot = slot;
		r.fill_level = fill;
		r.channel_total = tot;
		r.channel_count = cnt;
		r.outcome_total = otot;
		r.entry_chan = ech;
		r.entry_value = eval;
		return r;
	endfunction

	function automatic pvsa_pkg::rsp_t validate_and_store(input pvsa_pkg::req_t w);
		pvsa_pkg::rsp_t     r;
		pvsa_pkg::outcome_t oc;
		logic [5:0]         lim;
		logic [21:0]        sum;
		logic [1:0]         c;
		r = '0;
		lim = (reg_store_limit > 6'(STORE_SLOTS)) ? 6'(STORE_SLOTS) : reg_store_limit;
		if (w.req_type == pvsa_pkg::REQ_READ) begin
			if ({1'b0, w.read_index} < fill_count) begin
				r.entry_chan = entry_mem[w.read_index][17:16];
				r.entry_value = entry_mem[w.read_index][15:0];
			end
			r.outcome = pvsa_pkg::OC_ACCEPT;
			r.fill_level = fill_count;
			return r;
		end
		if (w.magic != reg_magic)
			oc = pvsa_pkg::OC_BAD_MAGIC;
		else if (w.len < reg_min_len || w.len > reg_max_len)
			oc = pvsa_pkg::OC_BAD_LEN;
		else if (w.chan >= 8'(CHANNELS))
			oc = pvsa_pkg::OC_BAD_CHAN;
		else if (w.crc != (w.magic ^ w.chan ^ w.len))
			oc = pvsa_pkg::OC_BAD_CHECK;
		else if (fill_count >= lim)
			oc = pvsa_pkg::OC_NO_SPACE;
		else
			oc = pvsa_pkg::OC_ACCEPT;
		if (oc == pvsa_pkg::OC_ACCEPT) begin
			c = w.chan[1:0];
			r.slot = fill_count[4:0];
			entry_mem[fill_count[4:0]] = {c, w.value};
			fill_count = fill_count + 6'd1;
			sum = {1'b0, lane_sum[c]} + {6'd0, w.value};
			lane_sum[c] = (sum > {1'b0, pvsa_pkg::SUM_MAX}) ? pvsa_pkg::SUM_MAX : sum[20:0];
			if (lane_count[c] != pvsa_pkg::CNT_MAX)
				lane_count[c] = lane_count[c] + 6'd1;
			r.channel_total = lane_sum[c];
			r.channel_count = lane_count[c];
		end
		if (tally_by_outcome[oc] != pvsa_pkg::TALLY_MAX)
			tally_by_outcome[oc] = tally_by_outcome[oc] + 16'd1;
		r.outcome = oc;
		r.fill_level = fill_count;
		r.outcome_total = tally_by_outcome[oc];
		return r;
	endfunction

	function automatic pvsa_pkg::req_t rand_word();
		pvsa_pkg::req_t w;
		int unsigned    pick;
		w.req_type = pvsa_pkg::REQ_SUBMIT;
		w.magic = reg_magic;
		w.chan = 8'($urandom_range(0, CHANNELS - 1));
		w.len = (reg_min_len <= reg_max_len) ?
			8'($urandom_range(reg_max_len, reg_min_len)) : 8'($urandom);
		pick = $urandom_range(0, 9);
		w.value = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF : 16'($urandom);
		w.crc = w.magic ^ w.chan ^ w.len;
		w.read_index = 5'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 15) begin
			w.req_type = pvsa_pkg::REQ_READ;
		end else if (pick >= 70) begin
			case (pick % 5)
				0: w.magic = w.magic ^ 8'($urandom_range(1, 255));
				1: w.len = 8'($urandom);
				2: w.chan = 8'($urandom_range(CHANNELS, 255));
				3: w.crc = w.crc ^ 8'($urandom_range(1, 255));
				default: begin
					w.magic = 8'($urandom);
					w.chan = 8'($urandom);
					w.len = 8'($urandom);
					w.crc = 8'($urandom);
				end
			endcase
		end
		return w;
	endfunction

	task automatic flag_mismatch(input string msg);
		mismatch_count++;
		$display("MISMATCH at %0t ns: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [31:0] got_v,
			input logic [31:0] want_v);
		if (got_v !== want_v)
			flag_mismatch($sformatf("%s got %0d want %0d", name, got_v, want_v));
	endtask

	always @(posedge clk) begin : result_check
		pvsa_pkg::rsp_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				flag_mismatch("result word with no expectation pending");
			end else begin
				want = pending_results.pop_front();
				check_field("outcome", 32'(result.outcome), 32'(want.outcome));
				check_field("slot", 32'(result.slot), 32'(want.slot));
				check_field("fill_level", 32'(result.fill_level), 32'(want.fill_level));
				check_field("channel_total", 32'(result.channel_total),
					32'(want.channel_total));
				check_field("channel_count", 32'(result.channel_count),
					32'(want.channel_count));
				check_field("outcome_total", 32'(result.outcome_total),
					32'(want.outcome_total));
				check_field("entry_chan", 32'(result.entry_chan), 32'(want.entry_chan));
				check_field("entry_value", 32'(result.entry_value), 32'(want.entry_value));
			end
		end
	end

	// hold the word until taken; start stays high for a following word
	task automatic issue(input pvsa_pkg::req_t w, input int idle_pct, input bit typed,
			input pvsa_pkg::rsp_t typed_want);
		pvsa_pkg::rsp_t predicted;
		if ($urandom_range(0, 99) < idle_pct) begin
			start = 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		start = 1'b1;
		req = w;
		do @(posedge clk); while (busy);
		predicted = validate_and_store(w);
		pending_results.push_back(typed ? typed_want : predicted);
		@(negedge clk);
	endtask

	task automatic drain_results();
		start = 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [7:0] idx, input logic [7:0] data);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			pvsa_pkg::CFG_MAGIC: reg_magic = data;
			pvsa_pkg::CFG_MIN_LEN: reg_min_len = data;
			pvsa_pkg::CFG_MAX_LEN: reg_max_len = data;
			pvsa_pkg::CFG_STORE_LIMIT: reg_store_limit = data[5:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic run_phase(input logic [7:0] magic, min_len, max_len, store_limit,
			input int idle_pct, input int n_words);
		drain_results();
		write_reg(pvsa_pkg::CFG_MAGIC, magic);
		write_reg(pvsa_pkg::CFG_MIN_LEN, min_len);
		write_reg(pvsa_pkg::CFG_MAX_LEN, max_len);
		write_reg(pvsa_pkg::CFG_STORE_LIMIT, store_limit);
		repeat (n_words) issue(rand_word(), idle_pct, 1'b0, '0);
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		reg_magic = pvsa_pkg::MAGIC_RST;
		reg_min_len = pvsa_pkg::MIN_LEN_RST;
		reg_max_len = pvsa_pkg::MAX_LEN_RST;
		reg_store_limit = pvsa_pkg::STORE_LIMIT_RST;
		fill_count = '0;
		for (int i = 0; i < CHANNELS; i++) begin
			lane_sum[i] = '0;
			lane_count[i] = '0;
		end
		for (int i = 0; i < pvsa_pkg::NUM_OUTCOMES; i++)
			tally_by_outcome[i] = '0;

		directed_rows.push_back('{rd(5'd0), 1'b1, result_word(pvsa_pkg::OC_ACCEPT,
			5'd0, 6'd0, 21'd0, 6'd0, 16'd0, 2'd0, 16'd0)});
		directed_rows.push_back('{rd(5'd31), 1'b1, result_word(pvsa_pkg::OC_ACCEPT,
			5'd0, 6'd0, 21'd0, 6'd0, 16'd0, 2'd0, 16'd0)});
		directed_rows.push_back('{sub(8'h00, 8'h00, 8'd4, 8'h00, 16'h1234), 1'b1,
			result_word(pvsa_pkg::OC_BAD_MAGIC, 5'd0, 6'd0, 21'd0, 6'd0, 16'd1, 2'd0, 16'd0)});
		directed_rows.push_back('{sub(8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF), 1'b1,
			result_word(pvsa_pkg::OC_BAD_MAGIC, 5'd0, 6'd0, 21'd0, 6'd0, 16'd2, 2'd0, 16'd0)});
		directed_rows.push_back('{sub(pvsa_pkg::MAGIC_RST, 8'd0, 8'd3,
			pvsa_pkg::MAGIC_RST ^ 8'd3, 16'h0007), 1'b1,
			result_word(pvsa_pkg::OC_BAD_LEN, 5'd0, 6'd0, 21'd0, 6'd0, 16'd1, 2'd0, 16'd0)});
		directed_rows.push_back('{sub(pvsa_pkg::MAGIC_RST, 8'd0, 8'd65,
			pvsa_pkg::MAGIC_RST ^ 8'd65, 16'h0007), 1'b1,
			result_word(pvsa_pkg::OC_BAD_LEN, 5'd0, 6'd0, 21'd0, 6'd0, 16'd2, 2'd0, 16'd0)});
		directed_rows.push_back('{sub(pvsa_pkg::MAGIC_RST, 8'd1, 8'd0,
			pvsa_pkg::MAGIC_RST ^ 8'd1, 16'h0000), 1'b1,
			result_word(pvsa_pkg::OC_BAD_LEN, 5'd0, 6'd0, 21'd0, 6'd0, 16'd3, 2'd0, 16'd0)});
		directed_rows.push_back('{sub(pvsa_pkg::MAGIC_RST, 8'd1, 8'd255,
			pvsa_pkg::MAGIC_RST ^ 8'd1 ^ 8'd255, 16'hFFFF), 1'b1,
			result_word(pvsa_pkg::OC_BAD_LEN, 5'd0, 6'd0, 21'd0, 6'd0, 16'd4, 2'd0, 16'd0)});
		directed_rows.push_back('{sub(pvsa_pkg::MAGIC_RST, 8'd4, 8'd4,
			pvsa_pkg::MAGIC_RST ^ 8'd4 ^ 8'd4, 16'h0001), 1'b1,
			result_word(pvsa_pkg::OC_BAD_CHAN, 5'd0, 6'd0, 21'd0, 6'd0, 16'd1, 2'd0, 16'd0)});
		directed_rows.push_back('{sub(pvsa_pkg::MAGIC_RST, 8'd255, 8'd64, 8'h00, 16'h8000),
			1'b1,
			result_word(pvsa_pkg::OC_BAD_CHAN, 5'd0, 6'd0, 21'd0, 6'd0, 16'd2, 2'd0, 16'd0)});
		directed_rows.push_back('{sub(pvsa_pkg::MAGIC_RST, 8'd2, 8'd10,
			pvsa_pkg::MAGIC_RST ^ 8'd2 ^ 8'd10 ^ 8'h01, 16'h00FF), 1'b1,
			result_word(pvsa_pkg::OC_BAD_CHECK, 5'd0, 6'd0, 21'd0, 6'd0, 16'd1, 2'd0, 16'd0)});
		directed_rows.push_back('{sub(pvsa_pkg::MAGIC_RST, 8'd2, 8'd10, 8'h00, 16'hFF00), 1'b1,
			result_word(pvsa_pkg::OC_BAD_CHECK, 5'd0, 6'd0, 21'd0, 6'd0, 16'd2, 2'd0, 16'd0)});
		directed_rows.push_back('{sub(pvsa_pkg::MAGIC_RST, 8'd0, 8'd4,
			pvsa_pkg::MAGIC_RST ^ 8'd4, 16'hFFFF), 1'b1,
			result_word(pvsa_pkg::OC_ACCEPT, 5'd0, 6'd1, 21'h00FFFF, 6'd1, 16'd1, 2'd0,
			16'd0)});
		directed_rows.push_back('{sub(pvsa_pkg::MAGIC_RST, 8'd3, 8'd64,
			pvsa_pkg::MAGIC_RST ^ 8'd3 ^ 8'd64, 16'h0000), 1'b1,
			result_word(pvsa_pkg::OC_ACCEPT, 5'd1, 6'd2, 21'd0, 6'd1, 16'd2, 2'd0, 16'd0)});
		directed_rows.push_back('{sub(pvsa_pkg::MAGIC_RST, 8'd3, 8'd33,
			pvsa_pkg::MAGIC_RST ^ 8'd3 ^ 8'd33, 16'hFFFF), 1'b0, '0});
		directed_rows.push_back('{sub(pvsa_pkg::MAGIC_RST, 8'd0, 8'd20,
			pvsa_pkg::MAGIC_RST ^ 8'd20, 16'h8001), 1'b0, '0});
		directed_rows.push_back('{rd(5'd0), 1'b1, result_word(pvsa_pkg::OC_ACCEPT,
			5'd0, 6'd4, 21'd0, 6'd0, 16'd0, 2'd0, 16'hFFFF)});
		directed_rows.push_back('{rd(5'd2), 1'b0, '0});
		directed_rows.push_back('{rd(5'd4), 1'b1, result_word(pvsa_pkg::OC_ACCEPT,
			5'd0, 6'd4, 21'd0, 6'd0, 16'd0, 2'd0, 16'd0)});
		directed_rows.push_back('{rd(5'd31), 1'b0, '0});
		directed_rows.push_back('{sub(pvsa_pkg::MAGIC_RST, 8'd1, 8'd4,
			pvsa_pkg::MAGIC_RST ^ 8'd1 ^ 8'd4, 16'h5555), 1'b0, '0});
		directed_rows.push_back('{sub(pvsa_pkg::MAGIC_RST, 8'd2, 8'd64,
			pvsa_pkg::MAGIC_RST ^ 8'd2 ^ 8'd64, 16'hAAAA), 1'b0, '0});
		directed_rows.push_back('{rd(5'd5), 1'b0, '0});

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_rows[i])
			issue(directed_rows[i].word, 30, directed_rows[i].typed, directed_rows[i].want);

		run_phase(8'h00, 8'd0, 8'd255, 8'd0, 30, 150);
		run_phase(8'hFF, 8'd200, 8'd100, 8'd24, 30, 150);
		run_phase(8'hA5, 8'd4, 8'd64, 8'd12, 30, 300);
		run_phase(8'h4D, 8'd255, 8'd255, 8'd20, 46, 300);
		run_phase(8'h3C, 8'd0, 8'd0, 8'd26, 46, 300);
		drain_results();
		write_reg(CFG_UNUSED_LO, 8'hFF);
		write_reg(CFG_UNUSED_HI, 8'h00);
		run_phase(pvsa_pkg::MAGIC_RST, pvsa_pkg::MIN_LEN_RST, pvsa_pkg::MAX_LEN_RST, 8'hFF,
			0, 530);

		drain_results();
		repeat (6) @(posedge clk);
		if (mismatch_count == 0)
			$display("packet_validate_store_aggregate_unit test passed");
		else
			$display("packet_validate_store_aggregate_unit test failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/pvsa_pkg.sv
design/packet_validate_store_aggregate_unit.sv
design/pvsa_checker.sv
verif/tb_packet_validate_store_aggregate_unit.sv
